@@ rtl/gblur_pkg.sv @@
// Shared types, kernel weights and constants of the 5x5 Gaussian blur.
`timescale 1ns / 1ps

package gblur_pkg;

  typedef struct packed {
    logic       command;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       frame_last;
  } pix_out_t;

  localparam logic CmdPixel = 1'b0;
  localparam logic CmdFlush = 1'b1;

  localparam logic CfgImageWidth  = 1'b0;
  localparam logic CfgImageHeight = 1'b1;

  localparam logic [11:0] ResetWidth  = 12'd640;
  localparam logic [12:0] ResetHeight = 13'd480;
  localparam logic [12:0] MaxHeight   = 13'd4096;

  // Division by 273 as a multiply by ceil(2^32 / 273) and a shift by 32.
  localparam logic [23:0] Recip273   = 24'd15732481;
  localparam int unsigned RecipShift = 32;

  localparam logic [5:0] Kernel [5][5] = '{
    '{6'd1, 6'd4,  6'd7,  6'd4,  6'd1},
    '{6'd4, 6'd16, 6'd26, 6'd16, 6'd4},
    '{6'd7, 6'd26, 6'd41, 6'd26, 6'd7},
    '{6'd4, 6'd16, 6'd26, 6'd16, 6'd4},
    '{6'd1, 6'd4,  6'd7,  6'd4,  6'd1}
  };

  function automatic logic [2:0] add_mod5(input logic [2:0] a, input logic [2:0] b);
    logic [3:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= 4'd5) begin
      sum = sum - 4'd5;
    end
    return sum[2:0];
  endfunction

endpackage

@@ rtl/gaussian_blur_5x5_rgb.sv @@
// Streaming 5x5 Gaussian blur of an RGB frame with five line slots in one memory.
`timescale 1ns / 1ps

// Pixels enter in raster order, one request per cycle unless the output stalls
// or a register write restarts the frame. Each output passes the snap, rows,
// tot and out registers after the request that completes its neighborhood,
// the pixel two rows and two columns further on. The line memory holds five
// rows, one lane per row slot, and is read once per output to fetch the next
// window column; writes that land on a fetched column are forwarded into the
// window. After the last pixel of a frame, flush requests (or pixel requests,
// whose data is then ignored) drain the remaining outputs one per request.

module gaussian_blur_5x5_rgb #(
  parameter int unsigned MaxWidth = 2048
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  gblur_pkg::pix_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output gblur_pkg::pix_out_t out_data_o,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [12:0]         cfg_data_i
);

  localparam int unsigned ColW = $clog2(MaxWidth);
  localparam int unsigned WW   = $clog2(MaxWidth + 1);
  localparam int unsigned DW   = WW + 2;

  logic [11:0]   width_q;
  logic [12:0]   height_q;
  logic [WW-1:0] w_eff;
  logic [12:0]   h_eff;

  logic [ColW-1:0] icol_q;
  logic [12:0]     irow_q;
  logic [2:0]      islot_q;
  logic [ColW-1:0] ocol_q;
  logic [12:0]     orow_q;
  logic [DW-1:0]   diff_q;
  logic [ColW-1:0] fcol_q;
  logic [2:0]      fbs_q;
  logic [4:0][ColW-1:0] tcol_q;
  logic [4:0][2:0]      tbs_q;
  logic            incoming_q;
  logic            restart_q;
  logic            lw_v_q;
  logic [ColW-1:0] lw_col_q;
  logic [2:0]      lw_slot_q;
  logic [23:0]     lw_pix_q;

  logic [4:0][4:0][23:0] win_q;
  logic [4:0][23:0]      line_mem [MaxWidth];
  logic [4:0][23:0]      rd_q;

  logic [4:0][ColW-1:0] init_tcol;
  logic [4:0][2:0]      init_tbs;
  logic [ColW-1:0]      init_fcol;
  logic [2:0]           init_fbs;

  logic            accept;
  logic            inputs_done;
  logic            is_pix;
  logic            emit;
  logic            last;
  logic [DW-1:0]   diff_inc;
  logic [DW-1:0]   thresh;
  logic [23:0]     pix;
  logic [4:0][4:0][23:0] win_e;
  logic [4:0][4:0][23:0] win_m;
  logic [4:0]      row_ok;
  logic [4:0]      col_ok;
  logic [WW:0]     ocol_x;
  logic [13:0]     orow_x;

  logic                  v0_q, v1_q, v2_q, vo_q;
  logic                  en0, en1, en2, eno;
  logic [4:0][4:0][23:0] snap_q;
  logic                  last0_q, last1_q, last2_q;
  logic [2:0][4:0][14:0] rows_q;
  logic [2:0][16:0]      tot_q;
  logic [2:0][4:0][14:0] rows_d;
  logic [2:0][16:0]      tot_d;
  logic [2:0][7:0]       q_d;
  gblur_pkg::pix_out_t   out_q;

  always_comb begin
    if (width_q == 12'd0) begin
      w_eff = WW'(1);
    end else if (32'(width_q) > 32'(MaxWidth)) begin
      w_eff = WW'(MaxWidth);
    end else begin
      w_eff = WW'(width_q);
    end
    if (height_q == 13'd0) begin
      h_eff = 13'd1;
    end else if (height_q > gblur_pkg::MaxHeight) begin
      h_eff = gblur_pkg::MaxHeight;
    end else begin
      h_eff = height_q;
    end
  end

  // Window column tags at frame start: the columns of raster positions 0 to 2
  // and the fetch position 3, which wrap into later rows on narrow frames.
  always_comb begin
    init_tcol = '0;
    init_tbs  = '0;
    init_tcol[2] = '0;
    init_tbs[2]  = 3'd3;
    if (w_eff == WW'(1)) begin
      init_tcol[3] = '0;
      init_tbs[3]  = 3'd4;
      init_tcol[4] = '0;
      init_tbs[4]  = 3'd0;
      init_fcol    = '0;
      init_fbs     = 3'd1;
    end else if (w_eff == WW'(2)) begin
      init_tcol[3] = ColW'(1);
      init_tbs[3]  = 3'd3;
      init_tcol[4] = '0;
      init_tbs[4]  = 3'd4;
      init_fcol    = ColW'(1);
      init_fbs     = 3'd4;
    end else if (w_eff == WW'(3)) begin
      init_tcol[3] = ColW'(1);
      init_tbs[3]  = 3'd3;
      init_tcol[4] = ColW'(2);
      init_tbs[4]  = 3'd3;
      init_fcol    = '0;
      init_fbs     = 3'd4;
    end else begin
      init_tcol[3] = ColW'(1);
      init_tbs[3]  = 3'd3;
      init_tcol[4] = ColW'(2);
      init_tbs[4]  = 3'd3;
      init_fcol    = ColW'(3);
      init_fbs     = 3'd3;
    end
  end

  assign eno = !vo_q || out_ready_i;
  assign en2 = !v2_q || eno;
  assign en1 = !v1_q || en2;
  assign en0 = !v0_q || en1;
  assign in_ready_o = en0 && !restart_q;

  assign accept      = in_valid_i && in_ready_o;
  assign inputs_done = irow_q >= h_eff;
  assign is_pix      = accept && !inputs_done && (in_data_i.command == gblur_pkg::CmdPixel);
  assign diff_inc    = diff_q + DW'(1);
  assign thresh      = DW'({w_eff, 1'b0}) + DW'(3);
  assign emit        = accept && (inputs_done || (is_pix && diff_inc >= thresh));
  assign last        = (orow_q == h_eff - 13'd1) && (WW'(ocol_q) == w_eff - WW'(1));
  assign pix         = {in_data_i.red_in, in_data_i.green_in, in_data_i.blue_in};
  assign ocol_x      = (WW + 1)'(ocol_q);
  assign orow_x      = {1'b0, orow_q};

  always_comb begin
    row_ok[0] = orow_q >= 13'd2;
    row_ok[1] = orow_q >= 13'd1;
    row_ok[2] = 1'b1;
    row_ok[3] = orow_x + 14'd1 < {1'b0, h_eff};
    row_ok[4] = orow_x + 14'd2 < {1'b0, h_eff};
    col_ok[0] = ocol_x >= (WW + 1)'(2);
    col_ok[1] = ocol_x >= (WW + 1)'(1);
    col_ok[2] = 1'b1;
    col_ok[3] = ocol_x + (WW + 1)'(1) < {1'b0, w_eff};
    col_ok[4] = ocol_x + (WW + 1)'(2) < {1'b0, w_eff};
  end

  // The newest column comes from the memory read with the write of the same
  // cycle patched in; any matching entry then takes the write of this request.
  always_comb begin
    for (int k = 0; k < 5; k++) begin
      for (int s = 0; s < 5; s++) begin
        win_e[k][s] = win_q[k][s];
        if (k == 4 && incoming_q) begin
          win_e[k][s] = rd_q[gblur_pkg::add_mod5(tbs_q[4], 3'(s))];
          if (lw_v_q && lw_col_q == tcol_q[4] &&
              lw_slot_q == gblur_pkg::add_mod5(tbs_q[4], 3'(s))) begin
            win_e[k][s] = lw_pix_q;
          end
        end
        if (is_pix && icol_q == tcol_q[k] &&
            islot_q == gblur_pkg::add_mod5(tbs_q[k], 3'(s))) begin
          win_e[k][s] = pix;
        end
        win_m[k][s] = (row_ok[s] && col_ok[k]) ? win_e[k][s] : 24'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= gblur_pkg::ResetWidth;
      height_q   <= gblur_pkg::ResetHeight;
      icol_q     <= '0;
      irow_q     <= '0;
      islot_q    <= '0;
      ocol_q     <= '0;
      orow_q     <= '0;
      diff_q     <= '0;
      fcol_q     <= ColW'(3);
      fbs_q      <= 3'd3;
      tcol_q     <= '0;
      tbs_q      <= '0;
      tcol_q[3]  <= ColW'(1);
      tcol_q[4]  <= ColW'(2);
      tbs_q[2]   <= 3'd3;
      tbs_q[3]   <= 3'd3;
      tbs_q[4]   <= 3'd3;
      incoming_q <= 1'b0;
      restart_q  <= 1'b0;
      lw_v_q     <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        gblur_pkg::CfgImageWidth:  width_q  <= cfg_data_i[11:0];
        gblur_pkg::CfgImageHeight: height_q <= cfg_data_i;
        default: ;
      endcase
      restart_q <= 1'b1;
    end else if (restart_q || (emit && last)) begin
      icol_q     <= '0;
      irow_q     <= '0;
      islot_q    <= '0;
      ocol_q     <= '0;
      orow_q     <= '0;
      diff_q     <= '0;
      fcol_q     <= init_fcol;
      fbs_q      <= init_fbs;
      tcol_q     <= init_tcol;
      tbs_q      <= init_tbs;
      incoming_q <= 1'b0;
      restart_q  <= 1'b0;
      lw_v_q     <= 1'b0;
    end else if (accept) begin
      lw_v_q    <= is_pix;
      lw_col_q  <= icol_q;
      lw_slot_q <= islot_q;
      lw_pix_q  <= pix;
      if (is_pix) begin
        if (WW'(icol_q) + WW'(1) >= w_eff) begin
          icol_q  <= '0;
          irow_q  <= irow_q + 13'd1;
          islot_q <= gblur_pkg::add_mod5(islot_q, 3'd1);
        end else begin
          icol_q <= icol_q + ColW'(1);
        end
      end
      if (emit) begin
        if (WW'(ocol_q) + WW'(1) >= w_eff) begin
          ocol_q <= '0;
          orow_q <= orow_q + 13'd1;
        end else begin
          ocol_q <= ocol_q + ColW'(1);
        end
        for (int k = 0; k < 4; k++) begin
          tcol_q[k] <= tcol_q[k + 1];
          tbs_q[k]  <= tbs_q[k + 1];
        end
        tcol_q[4] <= fcol_q;
        tbs_q[4]  <= fbs_q;
        if (WW'(fcol_q) + WW'(1) >= w_eff) begin
          fcol_q <= '0;
          fbs_q  <= gblur_pkg::add_mod5(fbs_q, 3'd1);
        end else begin
          fcol_q <= fcol_q + ColW'(1);
        end
        incoming_q <= 1'b1;
      end else begin
        incoming_q <= 1'b0;
        if (is_pix) begin
          diff_q <= diff_inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (emit) begin
        for (int k = 0; k < 4; k++) begin
          win_q[k] <= win_e[k + 1];
        end
        win_q[4] <= win_e[4];
      end else begin
        win_q <= win_e;
      end
    end
    if (is_pix) begin
      line_mem[icol_q][islot_q] <= pix;
    end
    if (emit && !last) begin
      rd_q <= line_mem[fcol_q];
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      for (int s = 0; s < 5; s++) begin
        rows_d[c][s] = '0;
        for (int k = 0; k < 5; k++) begin
          rows_d[c][s] = rows_d[c][s] + 15'(gblur_pkg::Kernel[s][k]) *
                         15'(snap_q[k][s][16 - 8 * c +: 8]);
        end
      end
      tot_d[c] = 17'(rows_q[c][0]) + 17'(rows_q[c][1]) + 17'(rows_q[c][2]) +
                 17'(rows_q[c][3]) + 17'(rows_q[c][4]);
    end
  end

  always_comb begin
    logic [40:0] prod;
    logic [8:0]  quo;
    for (int c = 0; c < 3; c++) begin
      prod = 41'(tot_q[c]) * 41'(gblur_pkg::Recip273);
      quo  = prod[gblur_pkg::RecipShift +: 9];
      q_d[c] = (quo > 9'd255) ? 8'd255 : quo[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en0) begin
        v0_q <= emit;
      end
      if (en1) begin
        v1_q <= v0_q;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (eno) begin
        vo_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en0 && emit) begin
      snap_q  <= win_m;
      last0_q <= last;
    end
    if (en1 && v0_q) begin
      rows_q  <= rows_d;
      last1_q <= last0_q;
    end
    if (en2 && v1_q) begin
      tot_q   <= tot_d;
      last2_q <= last1_q;
    end
    if (eno && v2_q) begin
      out_q.red_out    <= q_d[0];
      out_q.green_out  <= q_d[1];
      out_q.blue_out   <= q_d[2];
      out_q.frame_last <= last2_q;
    end
  end

  assign out_valid_o = vo_q;
  assign out_data_o  = out_q;

endmodule
